/* src/sgpf_pkg.sv */
package sgpf_pkg;

  localparam int CoordFracBits = 16;
  localparam int SqrtSteps     = 32;
  localparam int DivSteps      = 33;
  // Six front stages, the two root units, the denominator product (two stages),
  // the two dividers and four back stages.
  localparam int PipeDepth     = 6 + SqrtSteps + 2 + DivSteps + 4;

  localparam logic [31:0] EpsReset  = 32'd655;
  localparam logic [31:0] GainReset = 32'd65536;
  localparam logic [63:0] MagMax    = 64'h7FFF_FFFF_FFFF_FFFF;

  // Register index, taken from paddr[2].
  localparam logic RegEps  = 1'b0;
  localparam logic RegGain = 1'b1;

  typedef logic signed [11:0] exp_t;

  localparam exp_t ExpCoord  = exp_t'(-CoordFracBits);
  localparam exp_t ExpCoord2 = exp_t'(-2 * CoordFracBits);

  // Pseudo-float: value is m * 2^e, m normalised to [2^31, 2^32) or zero.
  typedef struct packed {
    logic [31:0] m;
    exp_t        e;
  } pf_t;

  typedef struct packed {
    logic [63:0] x;
    logic [35:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [32:0] q;
    logic [31:0] d;
    logic        lsb;
  } dv_t;

  typedef struct packed {
    pf_t  [2:0] adn;
    logic [2:0] neg;
  } axes_t;

  typedef struct packed {
    logic        sat;
    logic [63:0] mag;
  } q_t;

  typedef struct packed {
    axes_t ax;
    pf_t   sf;
    pf_t   num;
    exp_t  ers;
    exp_t  erp;
  } sqside_t;

  typedef struct packed {
    axes_t ax;
    exp_t  ec;
    exp_t  ep;
    logic  c_zero;
    logic  num_zero;
    logic  p_zero;
  } dvside_t;

  function automatic pf_t norm32(logic [31:0] u, exp_t e0);
    logic [31:0] x;
    logic [4:0]  lz;
    pf_t         r;
    x  = u;
    lz = '0;
    if (x[31:16] == '0) begin x = x << 16; lz[4] = 1'b1; end
    if (x[31:24] == '0) begin x = x << 8;  lz[3] = 1'b1; end
    if (x[31:28] == '0) begin x = x << 4;  lz[2] = 1'b1; end
    if (x[31:30] == '0) begin x = x << 2;  lz[1] = 1'b1; end
    if (!x[31]) begin x = x << 1; lz[0] = 1'b1; end
    r.m = x;
    r.e = e0 - exp_t'({7'd0, lz});
    return r;
  endfunction

  function automatic pf_t norm67(logic [66:0] u, exp_t e0);
    logic [127:0] x;
    logic [6:0]   lz;
    pf_t          r;
    x  = {u, 61'd0};
    lz = '0;
    if (x[127:64] == '0)  begin x = x << 64; lz[6] = 1'b1; end
    if (x[127:96] == '0)  begin x = x << 32; lz[5] = 1'b1; end
    if (x[127:112] == '0) begin x = x << 16; lz[4] = 1'b1; end
    if (x[127:120] == '0) begin x = x << 8;  lz[3] = 1'b1; end
    if (x[127:124] == '0) begin x = x << 4;  lz[2] = 1'b1; end
    if (x[127:126] == '0) begin x = x << 2;  lz[1] = 1'b1; end
    if (!x[127]) begin x = x << 1; lz[0] = 1'b1; end
    r.m = x[127:96];
    r.e = e0 + exp_t'(35) - exp_t'({5'd0, lz});
    return r;
  endfunction

  function automatic pf_t mul_fin(logic [63:0] p, exp_t es);
    pf_t r;
    if (p[63]) begin
      r.m = p[63:32];
      r.e = es + exp_t'(32);
    end else begin
      r.m = p[62:31];
      r.e = es + exp_t'(31);
    end
    return r;
  endfunction

  function automatic sq_t sqrt_init(pf_t a);
    sq_t s;
    s.x    = a.e[0] ? {1'b0, a.m, 31'd0} : {a.m, 32'd0};
    s.rem  = '0;
    s.root = '0;
    return s;
  endfunction

  function automatic exp_t sqrt_exp(pf_t a);
    exp_t t;
    t = a.e[0] ? (a.e - exp_t'(31)) : (a.e - exp_t'(32));
    return t >>> 1;
  endfunction

  // One result bit of the integer square root.
  function automatic sq_t sqrt_step(sq_t s);
    logic [35:0] rem2;
    logic [35:0] t;
    sq_t         r;
    rem2 = {s.rem[33:0], s.x[63:62]};
    t    = {2'b00, s.root, 2'b01};
    r.x  = s.x << 2;
    if (rem2 >= t) begin
      r.rem  = rem2 - t;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t div_init(logic [31:0] a, logic [31:0] b);
    dv_t s;
    s.rem = {1'b0, a[31:1]};
    s.lsb = a[0];
    s.q   = '0;
    s.d   = b;
    return s;
  endfunction

  // One quotient bit of (a << 32) / b; only the first step brings in a dividend bit.
  function automatic dv_t div_step(dv_t s);
    logic [32:0] r2;
    dv_t         r;
    r2    = {s.rem, s.lsb};
    r.d   = s.d;
    r.lsb = 1'b0;
    if (r2 >= {1'b0, s.d}) begin
      r.rem = 32'(r2 - {1'b0, s.d});
      r.q   = {s.q[31:0], 1'b1};
    end else begin
      r.rem = r2[31:0];
      r.q   = {s.q[31:0], 1'b0};
    end
    return r;
  endfunction

  function automatic pf_t div_fin(logic [32:0] q, exp_t ediff);
    pf_t r;
    if (q[32]) begin
      r.m = q[32:1];
      r.e = ediff - exp_t'(31);
    end else begin
      r.m = q[31:0];
      r.e = ediff - exp_t'(32);
    end
    return r;
  endfunction

  function automatic q_t to_q32(pf_t a);
    exp_t sh;
    exp_t nsh;
    q_t   r;
    sh    = a.e + exp_t'(32);
    nsh   = -sh;
    r.sat = 1'b0;
    r.mag = '0;
    if (a.m == '0) begin
      r.mag = '0;
    end else if (sh >= exp_t'(32)) begin
      r.sat = 1'b1;
      r.mag = MagMax;
    end else if (sh >= exp_t'(0)) begin
      r.mag = {32'd0, a.m} << sh[4:0];
    end else if (sh <= exp_t'(-32)) begin
      r.mag = '0;
    end else begin
      r.mag = {32'd0, a.m >> nsh[4:0]};
    end
    return r;
  endfunction

endpackage

/* src/softened_gravity_pair_force_top.sv */
// Channel  | Direction | Handshake                         | Word
// ---------+-----------+-----------------------------------+-------------------------------
// pair     | in        | start high while busy low         | two positions, two masses
// force    | out       | done_o high for one cycle         | six force axes, potential, flag
// config   | in        | APB write, psel/penable/pwrite    | eps at 0x0, gain at 0x4
//
// One pair word is taken in every cycle; busy never rises.
// Each word passes through the 32-step root unit and the 33-step divider,
// each retiring one bit per stage.
// Reset clears the valid bits and loads the register defaults; data stages are not cleared.
// The receiver cannot stall, so words are never held back.
module softened_gravity_pair_force_top import sgpf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] first_x_i,
  input  logic signed [31:0] first_y_i,
  input  logic signed [31:0] first_z_i,
  input  logic signed [31:0] second_x_i,
  input  logic signed [31:0] second_y_i,
  input  logic signed [31:0] second_z_i,
  input  logic        [31:0] first_mass_i,
  input  logic        [31:0] second_mass_i,
  output logic               done_o,
  output logic signed [63:0] first_force_x_o,
  output logic signed [63:0] first_force_y_o,
  output logic signed [63:0] first_force_z_o,
  output logic signed [63:0] second_force_x_o,
  output logic signed [63:0] second_force_y_o,
  output logic signed [63:0] second_force_z_o,
  output logic signed [63:0] pair_potential_o,
  output logic               saturated_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  logic [31:0] eps_q, gain_q;
  logic [PipeDepth-1:0] vld_q;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegGain) ? gain_q : eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q  <= EpsReset;
      gain_q <= GainReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegGain) begin
        gain_q <= pwdata;
      end else begin
        eps_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeDepth-2:0], start && !busy};
    end
  end

  // Stage 1: separation and its magnitude per axis.
  logic [2:0][31:0] pos_a, pos_b, abs_d;
  logic [2:0][32:0] diff;
  logic [2:0]       neg_d;

  assign pos_a = {first_z_i, first_y_i, first_x_i};
  assign pos_b = {second_z_i, second_y_i, second_x_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]  = {pos_b[i][31], pos_b[i]} - {pos_a[i][31], pos_a[i]};
      neg_d[i] = diff[i][32];
      abs_d[i] = neg_d[i] ? 32'(-diff[i]) : diff[i][31:0];
    end
  end

  logic [2:0][31:0] t1_ad_q;
  logic [2:0]       t1_neg_q;
  logic [31:0]      t1_m1_q, t1_m2_q;

  always_ff @(posedge clk_i) begin
    t1_ad_q  <= abs_d;
    t1_neg_q <= neg_d;
    t1_m1_q  <= first_mass_i;
    t1_m2_q  <= second_mass_i;
  end

  // Stage 2: squares and operand normalisation.
  logic [2:0][63:0] t2_sq_q;
  logic [63:0]      t2_e2_q;
  pf_t              t2_gn_q, t2_m1n_q, t2_m2n_q;
  axes_t            t2_ax_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      t2_sq_q[i]     <= {32'd0, t1_ad_q[i]} * {32'd0, t1_ad_q[i]};
      t2_ax_q.adn[i] <= norm32(t1_ad_q[i], ExpCoord);
    end
    t2_ax_q.neg <= t1_neg_q;
    t2_e2_q     <= {32'd0, eps_q} * {32'd0, eps_q};
    t2_gn_q     <= norm32(gain_q, ExpCoord);
    t2_m1n_q    <= norm32(t1_m1_q, ExpCoord);
    t2_m2n_q    <= norm32(t1_m2_q, ExpCoord);
  end

  // Stage 3
  logic [64:0] t3_a01_q;
  logic [63:0] t3_sq2_q, t3_e2_q, t3_p1_q;
  exp_t        t3_ep1_q;
  pf_t         t3_m2n_q;
  axes_t       t3_ax_q;

  always_ff @(posedge clk_i) begin
    t3_a01_q <= {1'b0, t2_sq_q[0]} + {1'b0, t2_sq_q[1]};
    t3_sq2_q <= t2_sq_q[2];
    t3_e2_q  <= t2_e2_q;
    t3_p1_q  <= {32'd0, t2_gn_q.m} * {32'd0, t2_m1n_q.m};
    t3_ep1_q <= t2_gn_q.e + t2_m1n_q.e;
    t3_m2n_q <= t2_m2n_q;
    t3_ax_q  <= t2_ax_q;
  end

  // Stage 4
  logic [65:0] t4_sumsq_q;
  logic [66:0] t4_s_q;
  logic [63:0] t4_e2_q;
  pf_t         t4_n1_q, t4_m2n_q;
  axes_t       t4_ax_q;

  always_ff @(posedge clk_i) begin
    t4_sumsq_q <= {1'b0, t3_a01_q} + {2'b00, t3_sq2_q};
    t4_s_q     <= {2'b00, t3_a01_q} + {3'b000, t3_sq2_q} + {3'b000, t3_e2_q};
    t4_e2_q    <= t3_e2_q;
    t4_n1_q    <= mul_fin(t3_p1_q, t3_ep1_q);
    t4_m2n_q   <= t3_m2n_q;
    t4_ax_q    <= t3_ax_q;
  end

  // Stage 5: the potential floors the squared distance at eps squared.
  pf_t         t5_sf_q;
  logic [65:0] t5_pv_q;
  logic [63:0] t5_p2_q;
  exp_t        t5_ep2_q;
  axes_t       t5_ax_q;

  always_ff @(posedge clk_i) begin
    t5_sf_q  <= norm67(t4_s_q, ExpCoord2);
    t5_pv_q  <= (t4_sumsq_q > {2'b00, t4_e2_q}) ? t4_sumsq_q : {2'b00, t4_e2_q};
    t5_p2_q  <= {32'd0, t4_n1_q.m} * {32'd0, t4_m2n_q.m};
    t5_ep2_q <= t4_n1_q.e + t4_m2n_q.e;
    t5_ax_q  <= t4_ax_q;
  end

  // Stage 6
  pf_t   t6_sf_q, t6_pp_q, t6_num_q;
  axes_t t6_ax_q;

  always_ff @(posedge clk_i) begin
    t6_sf_q  <= t5_sf_q;
    t6_pp_q  <= norm67({1'b0, t5_pv_q}, ExpCoord2);
    t6_num_q <= mul_fin(t5_p2_q, t5_ep2_q);
    t6_ax_q  <= t5_ax_q;
  end

  // Two root units side by side, one result bit per stage.
  sq_t     sqs_q [SqrtSteps];
  sq_t     sqp_q [SqrtSteps];
  sqside_t sqside_q [SqrtSteps];

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        sqs_q[j]        <= sqrt_step(sqrt_init(t6_sf_q));
        sqp_q[j]        <= sqrt_step(sqrt_init(t6_pp_q));
        sqside_q[j].ax  <= t6_ax_q;
        sqside_q[j].sf  <= t6_sf_q;
        sqside_q[j].num <= t6_num_q;
        sqside_q[j].ers <= sqrt_exp(t6_sf_q);
        sqside_q[j].erp <= sqrt_exp(t6_pp_q);
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        sqs_q[j]    <= sqrt_step(sqs_q[j-1]);
        sqp_q[j]    <= sqrt_step(sqp_q[j-1]);
        sqside_q[j] <= sqside_q[j-1];
      end
    end
  end

  // Denominator s * sqrt(s).
  logic [63:0] t39_dp_q;
  exp_t        t39_ed_q;
  pf_t         t39_num_q, t39_rp_q, t40_den_q, t40_num_q, t40_rp_q;
  axes_t       t39_ax_q, t40_ax_q;

  always_ff @(posedge clk_i) begin
    t39_dp_q   <= {32'd0, sqside_q[SqrtSteps-1].sf.m} * {32'd0, sqs_q[SqrtSteps-1].root};
    t39_ed_q   <= sqside_q[SqrtSteps-1].sf.e + sqside_q[SqrtSteps-1].ers;
    t39_num_q  <= sqside_q[SqrtSteps-1].num;
    t39_rp_q.m <= sqp_q[SqrtSteps-1].root;
    t39_rp_q.e <= sqside_q[SqrtSteps-1].erp;
    t39_ax_q   <= sqside_q[SqrtSteps-1].ax;
    t40_den_q  <= mul_fin(t39_dp_q, t39_ed_q);
    t40_num_q  <= t39_num_q;
    t40_rp_q   <= t39_rp_q;
    t40_ax_q   <= t39_ax_q;
  end

  // Two dividers side by side: force coefficient and potential.
  dv_t     dvc_q [DivSteps];
  dv_t     dvp_q [DivSteps];
  dvside_t dvside_q [DivSteps];

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        dvc_q[j]             <= div_step(div_init(t40_num_q.m, t40_den_q.m));
        dvp_q[j]             <= div_step(div_init(t40_num_q.m, t40_rp_q.m));
        dvside_q[j].ax       <= t40_ax_q;
        dvside_q[j].ec       <= t40_num_q.e - t40_den_q.e;
        dvside_q[j].ep       <= t40_num_q.e - t40_rp_q.e;
        dvside_q[j].c_zero   <= (t40_num_q.m == '0) || (t40_den_q.m == '0);
        dvside_q[j].num_zero <= (t40_num_q.m == '0);
        dvside_q[j].p_zero   <= (t40_rp_q.m == '0);
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        dvc_q[j]    <= div_step(dvc_q[j-1]);
        dvp_q[j]    <= div_step(dvp_q[j-1]);
        dvside_q[j] <= dvside_q[j-1];
      end
    end
  end

  // Back end: scale per axis, convert, negate.
  pf_t   t74_c_q, t74_pot_q;
  logic  t74_num_zero_q, t74_p_zero_q;
  axes_t t74_ax_q;

  always_ff @(posedge clk_i) begin
    t74_c_q        <= dvside_q[DivSteps-1].c_zero ? '0
                    : div_fin(dvc_q[DivSteps-1].q, dvside_q[DivSteps-1].ec);
    t74_pot_q      <= div_fin(dvp_q[DivSteps-1].q, dvside_q[DivSteps-1].ep);
    t74_num_zero_q <= dvside_q[DivSteps-1].num_zero;
    t74_p_zero_q   <= dvside_q[DivSteps-1].p_zero;
    t74_ax_q       <= dvside_q[DivSteps-1].ax;
  end

  q_t pot_q32;
  assign pot_q32 = to_q32(t74_pot_q);

  logic [2:0][63:0] t75_pr_q;
  exp_t [2:0]       t75_pe_q;
  logic [63:0]      t75_pm_q, t76_pm_q;
  logic             t75_psat_q, t76_psat_q;
  logic [2:0]       t75_neg_q, t76_neg_q;
  q_t   [2:0]       t76_fq_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      t75_pr_q[i] <= {32'd0, t74_c_q.m} * {32'd0, t74_ax_q.adn[i].m};
      t75_pe_q[i] <= t74_c_q.e + t74_ax_q.adn[i].e;
      t76_fq_q[i] <= to_q32(mul_fin(t75_pr_q[i], t75_pe_q[i]));
    end
    // Coincident particles without softening pin the potential at full scale.
    t75_pm_q   <= t74_num_zero_q ? '0 : (t74_p_zero_q ? MagMax : pot_q32.mag);
    t75_psat_q <= !t74_num_zero_q && (t74_p_zero_q || pot_q32.sat);
    t75_neg_q  <= t74_ax_q.neg;
    t76_pm_q   <= t75_pm_q;
    t76_psat_q <= t75_psat_q;
    t76_neg_q  <= t75_neg_q;
  end

  logic [2:0][63:0] out_first_q, out_second_q;
  logic [63:0]      out_pot_q;
  logic             out_sat_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      out_first_q[i]  <= t76_neg_q[i] ? -t76_fq_q[i].mag : t76_fq_q[i].mag;
      out_second_q[i] <= t76_neg_q[i] ? t76_fq_q[i].mag : -t76_fq_q[i].mag;
    end
    out_pot_q <= -t76_pm_q;
    out_sat_q <= t76_fq_q[0].sat || t76_fq_q[1].sat || t76_fq_q[2].sat || t76_psat_q;
  end

  assign done_o           = vld_q[PipeDepth-1];
  assign first_force_x_o  = out_first_q[0];
  assign first_force_y_o  = out_first_q[1];
  assign first_force_z_o  = out_first_q[2];
  assign second_force_x_o = out_second_q[0];
  assign second_force_y_o = out_second_q[1];
  assign second_force_z_o = out_second_q[2];
  assign pair_potential_o = out_pot_q;
  assign saturated_o      = out_sat_q;

`ifndef SYNTHESIS
  a_reaction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((first_force_x_o + second_force_x_o) == 64'sd0)
            && ((first_force_y_o + second_force_y_o) == 64'sd0)
            && ((first_force_z_o + second_force_z_o) == 64'sd0))
    else $error("second force is not the negation of the first");

  a_pot_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> pair_potential_o[63] || (pair_potential_o == 64'sd0))
    else $error("pair potential is positive");

  a_gain_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (paddr[2] == RegGain)) |=> (gain_q == $past(pwdata)))
    else $error("gain register write lost");
`endif

endmodule
